/* rtl/assert_macros.svh */
// assertion macros shared by the thermal fan curve rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tfc_pkg.sv */
// shared constants, types and stage map for the thermal fan curve
// no dependencies; imported by every other rtl module and interface
package tfc_pkg;

  // field widths
  localparam int TempW    = 15;
  localparam int PctW     = 7;
  localparam int DutyW    = 8;
  localparam int SpeedW   = 10;
  localparam int TimeW    = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // divider geometry, shared by the zone and speed dividers
  localparam int NumW  = 22;
  localparam int DenW  = 15;
  localparam int QuotW = 10;

  // zones
  localparam int NumZones = 3;
  localparam int ZoneBatt = 0;
  localparam int ZoneMod  = 1;
  localparam int ZoneInv  = 2;

  // stage map
  localparam int StFront   = 0;
  localparam int StMul     = 1;
  localparam int StZdiv    = 2;
  localparam int StPct     = StZdiv + QuotW;
  localparam int StSpd     = StPct + 1;
  localparam int StSdiv    = StSpd + 1;
  localparam int StOut     = StSdiv + QuotW;
  localparam int PipeDepth = StOut + 1;

  // arithmetic constants
  localparam int FullPct         = 100;
  localparam int DutyMax         = 255;
  localparam int SpeedFull       = 1000;
  localparam int SpeedFloor      = 10;
  localparam int StartupWindowMs = 2000;
  localparam int DMulW           = 15;
  localparam int DutyRecip       = 5243;
  localparam int DutyShift       = 19;
  localparam int DutyProdW       = 28;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgBattLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBattHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgModLow    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgModHigh   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInvLow    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgInvHigh   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMinPct    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgStartupEn = 3'd7;

  typedef logic [QuotW-1:0] quot_t;

  typedef struct packed {
    logic [TempW-1:0] batt_lo;
    logic [TempW-1:0] batt_hi;
    logic [TempW-1:0] mod_lo;
    logic [TempW-1:0] mod_hi;
    logic [TempW-1:0] inv_lo;
    logic [TempW-1:0] inv_hi;
    logic [PctW-1:0]  min_pct;
    logic             startup_en;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    batt_lo:    TempW'(3000),
    batt_hi:    TempW'(4500),
    mod_lo:     TempW'(4000),
    mod_hi:     TempW'(6000),
    inv_lo:     TempW'(4000),
    inv_hi:     TempW'(6000),
    min_pct:    PctW'(20),
    startup_en: 1'b0
  };

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } zone_op_t;

  typedef struct packed {
    logic [NumZones-1:0] below;
    logic [NumZones-1:0] full;
    logic                forced;
  } zone_side_t;

  typedef struct packed {
    logic [PctW-1:0]  pct;
    logic             zero;
    logic             full;
    logic             forced;
    logic [DutyW-1:0] duty;
  } spd_side_t;

  typedef struct packed {
    logic [PipeDepth-1:0] ld;
    logic [PipeDepth-1:0] vld;
  } pipe_ctl_t;

endpackage

/* rtl/tfc_if.sv */
// channel interfaces: sample input, result output, register write
// depends on tfc_pkg for field widths
interface tfc_sample_if import tfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_battery;
  logic signed [TempW-1:0] temp_module_a;
  logic signed [TempW-1:0] temp_module_b;
  logic signed [TempW-1:0] temp_inverter;
  logic [TimeW-1:0]        now_ms;

  modport source (output valid, temp_battery, temp_module_a, temp_module_b,
                  temp_inverter, now_ms, input ready);
  modport sink (input valid, temp_battery, temp_module_a, temp_module_b,
                temp_inverter, now_ms, output ready);
endinterface

interface tfc_result_if import tfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PctW-1:0]   fan_pct;
  logic [DutyW-1:0]  pwm_duty;
  logic [SpeedW-1:0] speed_permille;
  logic              startup_forced;

  modport source (output valid, fan_pct, pwm_duty, speed_permille, startup_forced,
                  input ready);
  modport sink (input valid, fan_pct, pwm_duty, speed_permille, startup_forced,
                output ready);
endinterface

interface tfc_cfg_if import tfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tfc_pipe_ctl.sv */
// valid bits and per-stage load enables for the whole pipeline
// depends on tfc_pkg and assert_macros.svh
`include "assert_macros.svh"

module tfc_pipe_ctl import tfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output pipe_ctl_t ctl
);

  localparam logic [PipeDepth-1:0] AllOnes = '1;

  logic [PipeDepth-1:0] vld;
  logic [PipeDepth-1:0] ld;

  // a stage loads when the output is ready or when it or any stage after it holds a bubble
  always_comb begin
    for (int i = 0; i < PipeDepth; i++) begin
      ld[i] = out_ready || ((vld >> i) != (AllOnes >> i));
    end
  end

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[StFront]) begin
        vld[StFront] <= in_valid;
      end
      for (int i = 1; i < PipeDepth; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready = ld[StFront];
  assign ctl.ld   = ld;
  assign ctl.vld  = vld;

  `ASSERT_IMPLY(a_full_stall, clk, rst, (&vld) && !out_ready, !in_ready, "full pipe took input")
  `ASSERT_NEXT(a_accept_lands, clk, rst, in_valid && in_ready, vld[StFront], "transaction lost")

endmodule

/* rtl/tfc_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on tfc_pkg; stage enables come from tfc_pipe_ctl
module tfc_div import tfc_pkg::*; (
  input  logic             clk,
  input  logic [QuotW-1:0] ld,
  input  logic [NumW-1:0]  num,
  input  logic [DenW-1:0]  den,
  output quot_t            quot
);

  localparam int TrialW = DenW + QuotW;

  logic [NumW-1:0]  rem [QuotW];
  logic [DenW-1:0]  dn  [QuotW];
  logic [QuotW-1:0] q   [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    localparam int Sh = QuotW - 1 - k;

    logic [NumW-1:0]   rem_in;
    logic [DenW-1:0]   den_in;
    logic [QuotW-1:0]  q_in;
    logic [TrialW-1:0] trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign den_in = dn[k-1];
      assign q_in   = q[k-1];
    end

    // compare against the shifted divisor and subtract when it fits
    assign trial = {{QuotW{1'b0}}, den_in} << Sh;
    assign take  = {{(TrialW-NumW){1'b0}}, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem[k] <= take ? (rem_in - trial[NumW-1:0]) : rem_in;
        dn[k]  <= den_in;
        q[k]   <= q_in | (take ? (QuotW'(1) << Sh) : '0);
      end
    end
  end

  assign quot = q[QuotW-1];

endmodule

/* rtl/tfc_front.sv */
// zone compare, ramp offset, start-up test window and ramp multiply
// depends on tfc_pkg and assert_macros.svh
`include "assert_macros.svh"

module tfc_front import tfc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_ctl_t               ctl,
  input  logic                    accept,
  input  logic signed [TempW-1:0] temp_battery,
  input  logic signed [TempW-1:0] temp_module_a,
  input  logic signed [TempW-1:0] temp_module_b,
  input  logic signed [TempW-1:0] temp_inverter,
  input  logic [TimeW-1:0]        now_ms,
  input  cfg_t                    cfg,
  input  logic [PctW-1:0]         span,
  output zone_op_t [NumZones-1:0] op,
  output zone_side_t              side
);

  logic signed [TempW-1:0] zt  [NumZones];
  logic signed [TempW-1:0] zlo [NumZones];
  logic signed [TempW-1:0] zhi [NumZones];

  logic [NumZones-1:0] below_c;
  logic [NumZones-1:0] full_c;
  logic [TempW-1:0]    diff_c [NumZones];
  logic [TempW-1:0]    den_c  [NumZones];

  logic [NumZones-1:0] s0_below;
  logic [NumZones-1:0] s0_full;
  logic [TempW-1:0]    s0_diff [NumZones];
  logic [TempW-1:0]    s0_den  [NumZones];
  logic                s0_forced;

  logic             seen;
  logic [TimeW-1:0] start_time;
  logic [TimeW-1:0] elapsed;
  logic             forced_c;

  // zone temperatures and thresholds, module zone takes the hotter sensor
  always_comb begin
    zt[ZoneBatt]  = temp_battery;
    zt[ZoneMod]   = (temp_module_a > temp_module_b) ? temp_module_a : temp_module_b;
    zt[ZoneInv]   = temp_inverter;
    zlo[ZoneBatt] = $signed(cfg.batt_lo);
    zhi[ZoneBatt] = $signed(cfg.batt_hi);
    zlo[ZoneMod]  = $signed(cfg.mod_lo);
    zhi[ZoneMod]  = $signed(cfg.mod_hi);
    zlo[ZoneInv]  = $signed(cfg.inv_lo);
    zhi[ZoneInv]  = $signed(cfg.inv_hi);
  end

  // ramp position per zone; offsets only matter inside the ramp
  always_comb begin
    for (int z = 0; z < NumZones; z++) begin
      below_c[z] = zt[z] < zlo[z];
      full_c[z]  = !below_c[z] && (zt[z] >= zhi[z]);
      diff_c[z]  = TempW'({zt[z][TempW-1], zt[z]} - {zlo[z][TempW-1], zlo[z]});
      den_c[z]   = TempW'({zhi[z][TempW-1], zhi[z]} - {zlo[z][TempW-1], zlo[z]});
    end
  end

  // start-up window, measured from the first transaction with the test on
  assign elapsed  = now_ms - (seen ? start_time : now_ms);
  assign forced_c = cfg.startup_en && (elapsed < TimeW'(StartupWindowMs));

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      start_time <= '0;
    end else if (accept && cfg.startup_en && !seen) begin
      seen       <= 1'b1;
      start_time <= now_ms;
    end
  end

  // stage 0 register
  always_ff @(posedge clk) begin
    if (ctl.ld[StFront]) begin
      s0_below  <= below_c;
      s0_full   <= full_c;
      s0_diff   <= diff_c;
      s0_den    <= den_c;
      s0_forced <= forced_c;
    end
  end

  // stage 1: offset times ramp span
  always_ff @(posedge clk) begin
    if (ctl.ld[StMul]) begin
      for (int z = 0; z < NumZones; z++) begin
        op[z].num <= {{(NumW-TempW){1'b0}}, s0_diff[z]} * {{(NumW-PctW){1'b0}}, span};
        op[z].den <= s0_den[z];
      end
      side.below  <= s0_below;
      side.full   <= s0_full;
      side.forced <= s0_forced;
    end
  end

  `ASSERT_NEXT(a_startup_latch, clk, rst, accept && cfg.startup_en, seen, "start-up not latched")

endmodule

/* rtl/tfc_back.sv */
// zone percent merge, duty scaling, speed divide and output register
// depends on tfc_pkg, tfc_div and assert_macros.svh
`include "assert_macros.svh"

module tfc_back import tfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  pipe_ctl_t            ctl,
  input  quot_t [NumZones-1:0] quot,
  input  zone_side_t           side,
  input  logic [PctW-1:0]      min_sat,
  input  logic [PctW-1:0]      span,
  output logic [PctW-1:0]      fan_pct,
  output logic [DutyW-1:0]     pwm_duty,
  output logic [SpeedW-1:0]    speed_permille,
  output logic                 startup_forced
);

  logic [PctW-1:0] zp [NumZones];
  logic [PctW-1:0] pct_c;

  logic [PctW-1:0] p_pct;
  logic            p_forced;

  logic [PctW-1:0]  diff_pct;
  logic [NumW-1:0]  m_num;
  logic [DMulW-1:0] m_dmul;
  logic [PctW-1:0]  m_pct;
  logic             m_zero;
  logic             m_full;
  logic             m_forced;

  logic [DutyProdW-1:0] duty_prod;
  spd_side_t            sd [QuotW];
  quot_t                spd_q;
  logic [SpeedW-1:0]    speed_c;

  // per-zone percent and the largest of them
  always_comb begin
    pct_c = '0;
    for (int z = 0; z < NumZones; z++) begin
      if (side.below[z]) begin
        zp[z] = '0;
      end else if (side.full[z]) begin
        zp[z] = PctW'(FullPct);
      end else begin
        zp[z] = min_sat + quot[z][PctW-1:0];
      end
      if (zp[z] > pct_c) begin
        pct_c = zp[z];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[StPct]) begin
      p_pct    <= pct_c;
      p_forced <= side.forced;
    end
  end

  // speed numerator and duty product
  assign diff_pct = (p_pct > min_sat) ? (p_pct - min_sat) : '0;

  always_ff @(posedge clk) begin
    if (ctl.ld[StSpd]) begin
      m_num    <= {{(NumW-PctW){1'b0}}, diff_pct} * NumW'(SpeedFull);
      m_dmul   <= {{(DMulW-PctW){1'b0}}, p_pct} * DMulW'(DutyMax);
      m_pct    <= p_pct;
      m_zero   <= (p_pct == '0);
      m_full   <= (p_pct >= PctW'(FullPct)) || (min_sat >= PctW'(FullPct));
      m_forced <= p_forced;
    end
  end

  // speed divide by the ramp span
  tfc_div u_spd_div (
    .clk  (clk),
    .ld   (ctl.ld[StSdiv +: QuotW]),
    .num  (m_num),
    .den  ({{(DenW-PctW){1'b0}}, span}),
    .quot (spd_q)
  );

  // divide by 100 through a reciprocal multiply
  assign duty_prod = {{(DutyProdW-DMulW){1'b0}}, m_dmul} * DutyProdW'(DutyRecip);

  // side data travels beside the speed divider
  always_ff @(posedge clk) begin
    if (ctl.ld[StSdiv]) begin
      sd[0].pct    <= m_pct;
      sd[0].zero   <= m_zero;
      sd[0].full   <= m_full;
      sd[0].forced <= m_forced;
      sd[0].duty   <= DutyW'(duty_prod >> DutyShift);
    end
    for (int k = 1; k < QuotW; k++) begin
      if (ctl.ld[StSdiv + k]) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // speed clamp
  always_comb begin
    if (sd[QuotW-1].zero) begin
      speed_c = '0;
    end else if (sd[QuotW-1].full) begin
      speed_c = SpeedW'(SpeedFull);
    end else if (spd_q < QuotW'(SpeedFloor)) begin
      speed_c = SpeedW'(SpeedFloor);
    end else if (spd_q > QuotW'(SpeedFull)) begin
      speed_c = SpeedW'(SpeedFull);
    end else begin
      speed_c = spd_q;
    end
  end

  // output register, start-up test overrides everything
  always_ff @(posedge clk) begin
    if (ctl.ld[StOut]) begin
      if (sd[QuotW-1].forced) begin
        fan_pct        <= PctW'(FullPct);
        pwm_duty       <= DutyW'(DutyMax);
        speed_permille <= SpeedW'(SpeedFull);
        startup_forced <= 1'b1;
      end else begin
        fan_pct        <= sd[QuotW-1].pct;
        pwm_duty       <= sd[QuotW-1].duty;
        speed_permille <= speed_c;
        startup_forced <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLY(a_full_consistent, clk, rst, ctl.vld[StOut] && (fan_pct == PctW'(FullPct)), (pwm_duty == DutyW'(DutyMax)) && (speed_permille == SpeedW'(SpeedFull)), "full fan mismatch")
  `ASSERT_IMPLY(a_off_consistent, clk, rst, ctl.vld[StOut] && (fan_pct == '0), (pwm_duty == '0) && (speed_permille == '0), "fan off mismatch")

endmodule

/* rtl/thermal_fan_curve.sv */
// fan demand as the max of three linear zone ramps, one transaction per cycle while results are taken
// a 25-stage pipeline holding two ten-stage restoring dividers (zone ramp and speed)
// throughput: one transaction per cycle while results are taken, any stage with a bubble keeps moving
// reset: registers to default thresholds, start-up test flag cleared, pipe empty
// depends on tfc_pkg, tfc_if, tfc_pipe_ctl, tfc_front, tfc_div, tfc_back
module thermal_fan_curve import tfc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tfc_sample_if.sink   sample,
  tfc_result_if.source result,
  tfc_cfg_if.sink      cfg
);

  cfg_t                    cfg_reg;
  logic [PctW-1:0]         min_sat;
  logic [PctW-1:0]         span;
  pipe_ctl_t               ctl;
  logic                    in_ready;
  logic                    accept;
  zone_op_t [NumZones-1:0] op;
  zone_side_t              side;
  zone_side_t              zd [QuotW];
  quot_t [NumZones-1:0]    zq;

  // register writes, held off during reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= CfgReset;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CfgBattLow:   cfg_reg.batt_lo    <= cfg.data[TempW-1:0];
        CfgBattHigh:  cfg_reg.batt_hi    <= cfg.data[TempW-1:0];
        CfgModLow:    cfg_reg.mod_lo     <= cfg.data[TempW-1:0];
        CfgModHigh:   cfg_reg.mod_hi     <= cfg.data[TempW-1:0];
        CfgInvLow:    cfg_reg.inv_lo     <= cfg.data[TempW-1:0];
        CfgInvHigh:   cfg_reg.inv_hi     <= cfg.data[TempW-1:0];
        CfgMinPct:    cfg_reg.min_pct    <= cfg.data[PctW-1:0];
        CfgStartupEn: cfg_reg.startup_en <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // minimum percent saturates at full
  assign min_sat = (cfg_reg.min_pct > PctW'(FullPct)) ? PctW'(FullPct) : cfg_reg.min_pct;
  assign span    = PctW'(FullPct) - min_sat;

  // pipeline control
  tfc_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .out_ready (result.ready),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  // no transaction is taken while in reset
  assign sample.ready = in_ready && !rst;
  assign accept       = sample.valid && sample.ready;

  tfc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .accept        (accept),
    .temp_battery  (sample.temp_battery),
    .temp_module_a (sample.temp_module_a),
    .temp_module_b (sample.temp_module_b),
    .temp_inverter (sample.temp_inverter),
    .now_ms        (sample.now_ms),
    .cfg           (cfg_reg),
    .span          (span),
    .op            (op),
    .side          (side)
  );

  // one ramp divider per zone
  for (genvar z = 0; z < NumZones; z++) begin : g_zone_div
    tfc_div u_div (
      .clk  (clk),
      .ld   (ctl.ld[StZdiv +: QuotW]),
      .num  (op[z].num),
      .den  (op[z].den),
      .quot (zq[z])
    );
  end

  // zone flags travel beside the dividers
  always_ff @(posedge clk) begin
    if (ctl.ld[StZdiv]) begin
      zd[0] <= side;
    end
    for (int k = 1; k < QuotW; k++) begin
      if (ctl.ld[StZdiv + k]) begin
        zd[k] <= zd[k-1];
      end
    end
  end

  tfc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .quot           (zq),
    .side           (zd[QuotW-1]),
    .min_sat        (min_sat),
    .span           (span),
    .fan_pct        (result.fan_pct),
    .pwm_duty       (result.pwm_duty),
    .speed_permille (result.speed_permille),
    .startup_forced (result.startup_forced)
  );

  assign result.valid = ctl.vld[StOut];

endmodule

/* test/tb_thermal_fan_curve.sv */
// self-checking testbench for thermal_fan_curve: directed table, then random phases
// depends on tfc_pkg and the channel interfaces in tfc_if, drives the dut through them
module tb_thermal_fan_curve import tfc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cold          = -(1 << (TempW - 1));
  localparam int Hot           = (1 << (TempW - 1)) - 1;
  localparam int MismatchShown = 10;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 40;
  localparam int ItemsPerPhase = 100;
  localparam int NumPhases     = 11;

  localparam logic [CfgIdxW-1:0] LowIdx [NumZones]  = '{CfgBattLow, CfgModLow, CfgInvLow};
  localparam logic [CfgIdxW-1:0] HighIdx [NumZones] = '{CfgBattHigh, CfgModHigh, CfgInvHigh};

  typedef struct packed {
    logic signed [TempW-1:0] battery;
    logic signed [TempW-1:0] module_a;
    logic signed [TempW-1:0] module_b;
    logic signed [TempW-1:0] inverter;
    logic [TimeW-1:0]        now_ms;
  } sample_t;

  typedef struct packed {
    logic [PctW-1:0]   pct;
    logic [DutyW-1:0]  duty;
    logic [SpeedW-1:0] speed;
    logic              forced;
  } fan_out_t;

  typedef enum bit {RowItem, RowCfg} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    sample_t             smp;
    bit                  known;
    fan_out_t            want;
  } stim_row_t;

  logic clk;
  logic rst;

  tfc_sample_if sample_ch ();
  tfc_result_if result_ch ();
  tfc_cfg_if    cfg_ch ();

  thermal_fan_curve dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // shadow of the block: registers and start-up test state
  cfg_t             model_cfg = CfgReset;
  bit               startup_seen;
  logic [TimeW-1:0] startup_stamp;

  fan_out_t  fan_results_due[$];
  stim_row_t directed_rows[$];
  int        failures;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one zone ramp
  function automatic int zone_demand(int t, int lo, int hi, int floor_pct);
    if (t < lo) return 0;
    if (t >= hi) return FullPct;
    return floor_pct + ((t - lo) * (FullPct - floor_pct)) / (hi - lo);
  endfunction

  // fan demand for one sample, advances the start-up test state
  function automatic fan_out_t compute_fan_demand(sample_t s);
    fan_out_t         r;
    int               floor_pct;
    int               t_mod;
    int               pct;
    int               speed;
    logic [TimeW-1:0] elapsed;
    floor_pct = int'(model_cfg.min_pct);
    if (floor_pct > FullPct) floor_pct = FullPct;
    if (model_cfg.startup_en) begin
      if (!startup_seen) begin
        startup_seen  = 1'b1;
        startup_stamp = s.now_ms;
      end
      elapsed = s.now_ms - startup_stamp;
      if (elapsed < TimeW'(StartupWindowMs)) begin
        r = {PctW'(FullPct), DutyW'(DutyMax), SpeedW'(SpeedFull), 1'b1};
        return r;
      end
    end
    t_mod = (int'(s.module_a) > int'(s.module_b)) ? int'(s.module_a) : int'(s.module_b);
    pct = zone_demand(int'(s.battery), int'($signed(model_cfg.batt_lo)),
                      int'($signed(model_cfg.batt_hi)), floor_pct);
    speed = zone_demand(t_mod, int'($signed(model_cfg.mod_lo)),
                        int'($signed(model_cfg.mod_hi)), floor_pct);
    if (speed > pct) pct = speed;
    speed = zone_demand(int'(s.inverter), int'($signed(model_cfg.inv_lo)),
                        int'($signed(model_cfg.inv_hi)), floor_pct);
    if (speed > pct) pct = speed;
    // speed within the ramp
    if (pct <= 0) begin
      speed = 0;
    end else if (pct >= FullPct || floor_pct >= FullPct) begin
      speed = SpeedFull;
    end else begin
      speed = ((pct - floor_pct) * SpeedFull) / (FullPct - floor_pct);
      if (speed < SpeedFloor) speed = SpeedFloor;
      if (speed > SpeedFull) speed = SpeedFull;
    end
    r = {PctW'(pct), DutyW'((pct * DutyMax) / FullPct), SpeedW'(speed), 1'b0};
    return r;
  endfunction

  function automatic sample_t temps_at(int b, int ma, int mb, int inv, logic [TimeW-1:0] now);
    sample_t s;
    s = {TempW'(b), TempW'(ma), TempW'(mb), TempW'(inv), now};
    return s;
  endfunction

  function automatic stim_row_t item_row(sample_t s);
    stim_row_t r;
    r.kind  = RowItem;
    r.idx   = '0;
    r.data  = '0;
    r.smp   = s;
    r.known = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(sample_t s, int pct, int duty, int speed, bit forced);
    stim_row_t r;
    r       = item_row(s);
    r.known = 1'b1;
    r.want  = {PctW'(pct), DutyW'(duty), SpeedW'(speed), forced};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    stim_row_t r;
    r      = item_row('0);
    r.kind = RowCfg;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // temperature mostly around a zone ramp, sometimes anywhere or at the rails
  function automatic logic signed [TempW-1:0] near_ramp(logic [TempW-1:0] lo_raw,
                                                        logic [TempW-1:0] hi_raw);
    int lo;
    int hi;
    int base;
    int span;
    int v;
    lo = int'($signed(lo_raw));
    hi = int'($signed(hi_raw));
    case ($urandom_range(0, 9))
      0: return TempW'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? TempW'(Cold) : TempW'(Hot);
      default: begin
        base = (lo < hi) ? lo : hi;
        span = (lo < hi) ? hi - lo : lo - hi;
        v = base - 100 + int'($urandom_range(0, span + 200));
        if (v < Cold) v = Cold;
        if (v > Hot) v = Hot;
        return TempW'(v);
      end
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.battery  = near_ramp(model_cfg.batt_lo, model_cfg.batt_hi);
    s.module_a = near_ramp(model_cfg.mod_lo, model_cfg.mod_hi);
    s.module_b = near_ramp(model_cfg.mod_lo, model_cfg.mod_hi);
    s.inverter = near_ramp(model_cfg.inv_lo, model_cfg.inv_hi);
    // keep time stamps close to the start-up window edge while the test is on
    if (model_cfg.startup_en && startup_seen && $urandom_range(0, 3) != 0)
      s.now_ms = startup_stamp + TimeW'($urandom_range(0, 2 * StartupWindowMs));
    else
      s.now_ms = $urandom;
    return s;
  endfunction

  task automatic report(string what, fan_out_t want, fan_out_t got);
    failures++;
    if (failures <= MismatchShown)
      $display("%s: expected pct/duty/speed/forced %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
               what, want.pct, want.duty, want.speed, want.forced,
               got.pct, got.duty, got.speed, got.forced);
  endtask

  // one sample transaction, with random gaps before it
  task automatic drive_item(sample_t s, bit use_known, fan_out_t known);
    fan_out_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.temp_battery  <= s.battery;
    sample_ch.temp_module_a <= s.module_a;
    sample_ch.temp_module_b <= s.module_b;
    sample_ch.temp_inverter <= s.inverter;
    sample_ch.now_ms        <= s.now_ms;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = compute_fan_demand(s);
    fan_results_due.push_back(use_known ? known : predicted);
  endtask

  // stop sending and let every pending result come out
  task automatic wait_drained();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (fan_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CfgBattLow:   model_cfg.batt_lo    = data[TempW-1:0];
      CfgBattHigh:  model_cfg.batt_hi    = data[TempW-1:0];
      CfgModLow:    model_cfg.mod_lo     = data[TempW-1:0];
      CfgModHigh:   model_cfg.mod_hi     = data[TempW-1:0];
      CfgInvLow:    model_cfg.inv_lo     = data[TempW-1:0];
      CfgInvHigh:   model_cfg.inv_hi     = data[TempW-1:0];
      CfgMinPct:    model_cfg.min_pct    = data[PctW-1:0];
      CfgStartupEn: model_cfg.startup_en = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // new thresholds, floor and start-up enable for one phase
  task automatic randomize_registers(int phase);
    int lo;
    int hi;
    int sel;
    int floor_pct;
    for (int z = 0; z < NumZones; z++) begin
      if (phase == 0) sel = 0;
      else if (phase == 1) sel = 3;
      else sel = $urandom_range(0, 12);
      case (sel)
        0: begin
          lo = Cold;
          hi = Hot;
        end
        1: begin
          hi = int'($urandom_range(0, 15500)) - 5500;
          lo = hi + int'($urandom_range(1, 3000));
        end
        2: begin
          lo = int'($urandom_range(0, 18000)) - 5500;
          hi = lo;
        end
        3: begin
          lo = Hot;
          hi = Cold;
        end
        default: begin
          lo = int'($urandom_range(0, 15500)) - 5500;
          hi = lo + int'($urandom_range(1, 2500));
        end
      endcase
      write_register(LowIdx[z], {1'($urandom_range(0, 1)), TempW'(lo)});
      write_register(HighIdx[z], {1'($urandom_range(0, 1)), TempW'(hi)});
    end
    if (phase == 0) floor_pct = 0;
    else if (phase == 1) floor_pct = FullPct;
    else begin
      case ($urandom_range(0, 7))
        0:       floor_pct = 0;
        1:       floor_pct = FullPct;
        2:       floor_pct = $urandom_range(FullPct + 1, (1 << PctW) - 1);
        default: floor_pct = $urandom_range(1, FullPct - 1);
      endcase
    end
    write_register(CfgMinPct, {(CfgDataW - PctW)'($urandom), PctW'(floor_pct)});
    write_register(CfgStartupEn, {(CfgDataW - 1)'($urandom), (phase % 3) == 2});
  endtask

  // receiver stalls
  always @(negedge clk) result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    fan_out_t got;
    fan_out_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.fan_pct, result_ch.pwm_duty, result_ch.speed_permille,
             result_ch.startup_forced};
      if (fan_results_due.size() == 0) begin
        report("result with nothing pending", got, got);
      end else begin
        want = fan_results_due.pop_front();
        if (got.pct !== want.pct || got.duty !== want.duty ||
            got.speed !== want.speed || got.forced !== want.forced)
          report("result mismatch", want, got);
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("thermal_fan_curve regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                     = 1'b1;
    sample_ch.valid         = 1'b0;
    sample_ch.temp_battery  = '0;
    sample_ch.temp_module_a = '0;
    sample_ch.temp_module_b = '0;
    sample_ch.temp_inverter = '0;
    sample_ch.now_ms        = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;
    result_ch.ready         = 1'b0;
    send_idle_pct           = 26;
    recv_idle_pct           = 46;
    failures                = 0;
    quiet_cycles            = 0;

    // directed table: rails, ramp points, floor cases, crossed thresholds, start-up window
    directed_rows.push_back(known_row(temps_at(Cold, Cold, Cold, Cold, '0), 0, 0, 0, 0));
    directed_rows.push_back(known_row(temps_at(Hot, Hot, Hot, Hot, '1), 100, 255, 1000, 0));
    directed_rows.push_back(known_row(temps_at(3000, Cold, Cold, Cold, '0), 20, 51, 10, 0));
    directed_rows.push_back(item_row(temps_at(4499, Cold, Cold, Cold, '0)));
    directed_rows.push_back(item_row(temps_at(Cold, 5000, Cold, Cold, '0)));
    directed_rows.push_back(item_row(temps_at(Cold, 4100, 5000, Cold, '0)));
    directed_rows.push_back(item_row(temps_at(3500, Cold, Cold, 5999, '0)));
    // floor of zero: ramp start gives nothing
    directed_rows.push_back(reg_row(CfgMinPct, 16'd0));
    directed_rows.push_back(known_row(temps_at(3000, Cold, Cold, Cold, '0), 0, 0, 0, 0));
    directed_rows.push_back(item_row(temps_at(3015, Cold, Cold, Cold, '0)));
    // floor above full saturates
    directed_rows.push_back(reg_row(CfgMinPct, 16'h007f));
    directed_rows.push_back(known_row(temps_at(3000, Cold, Cold, Cold, '0), 100, 255, 1000, 0));
    directed_rows.push_back(reg_row(CfgMinPct, 16'hff94));
    // crossed battery thresholds
    directed_rows.push_back(reg_row(CfgBattLow, 16'd5000));
    directed_rows.push_back(reg_row(CfgBattHigh, 16'd4000));
    directed_rows.push_back(known_row(temps_at(4999, Cold, Cold, Cold, '0), 0, 0, 0, 0));
    directed_rows.push_back(known_row(temps_at(5000, Cold, Cold, Cold, '0), 100, 255, 1000, 0));
    directed_rows.push_back(item_row(temps_at(4500, 5500, Cold, Cold, '0)));
    directed_rows.push_back(reg_row(CfgBattLow, 16'h8bb8));
    directed_rows.push_back(reg_row(CfgBattHigh, 16'd4500));
    // start-up window latched just before the time stamp wraps
    directed_rows.push_back(reg_row(CfgStartupEn, 16'd1));
    directed_rows.push_back(known_row(temps_at(Cold, Cold, Cold, Cold, 32'hffff_fc00),
                                      100, 255, 1000, 1));
    directed_rows.push_back(known_row(temps_at(Hot, Cold, Cold, Cold, 32'h0000_0300),
                                      100, 255, 1000, 1));
    directed_rows.push_back(known_row(temps_at(Cold, Cold, Cold, Cold, 32'h0000_03d0),
                                      0, 0, 0, 0));
    directed_rows.push_back(reg_row(CfgStartupEn, 16'd0));
    directed_rows.push_back(known_row(temps_at(Cold, Cold, Cold, Cold, 32'hffff_fc10),
                                      0, 0, 0, 0));
    // flag stays set once seen, window reopens on the same stamp
    directed_rows.push_back(reg_row(CfgStartupEn, 16'd1));
    directed_rows.push_back(known_row(temps_at(Cold, Cold, Cold, Cold, 32'hffff_fd00),
                                      100, 255, 1000, 1));
    directed_rows.push_back(reg_row(CfgStartupEn, 16'hfffe));
    directed_rows.push_back(item_row(temps_at(4000, 6000, 3999, 4000, 32'h0000_1000)));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowCfg) begin
        wait_drained();
        write_register(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        drive_item(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].want);
      end
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 26;
        recv_idle_pct = 46;
      end else if (ph < 8) begin
        send_idle_pct = 46;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      randomize_registers(ph);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // hold off once until the pipe is empty
        if (ph == 2 && n == ItemsPerPhase / 2) wait_drained();
        drive_item(random_sample(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    failures += fan_results_due.size();
    if (failures == 0)
      $display("thermal_fan_curve regression: pass");
    else
      $display("thermal_fan_curve regression: fail");
    $finish;
  end

endmodule
